// ----- design/ipv4hv_pkg.sv -----
// Package for the IPv4 header verifier: sizes, field codes, error codes,
// and the state and verdict structs shared by the step logic and the top level.
// No dependencies.
package ipv4hv_pkg;

  localparam int HdrBytes = 20;
  localparam int IdxW     = 5;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HdrBytes - 1);

  // byte positions that carry checked fields
  localparam logic [IdxW-1:0] IdxVerIhl   = IdxW'(0);
  localparam logic [IdxW-1:0] IdxLenLo    = IdxW'(3);
  localparam logic [IdxW-1:0] IdxFragLo   = IdxW'(7);
  localparam logic [IdxW-1:0] IdxProto    = IdxW'(9);
  localparam logic [IdxW-1:0] IdxCsumLo   = IdxW'(11);

  localparam logic [7:0]  VerIhlExpected = 8'h45;
  localparam logic [12:0] FragOffMask    = 13'h1FFF;
  localparam logic [7:0]  ProtoIcmp      = 8'd1;
  localparam logic [7:0]  ProtoTcp       = 8'd6;
  localparam logic [7:0]  ProtoUdp       = 8'd17;

  localparam logic [15:0] MinLenReset = 16'd20;
  localparam logic [15:0] MaxLenReset = 16'd1500;

  // configuration register indexes
  typedef enum logic {
    CFG_MIN_LEN = 1'b0,
    CFG_MAX_LEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_VERSION  = 3'd1,
    ERR_LENGTH   = 3'd2,
    ERR_FRAGMENT = 3'd3,
    ERR_PROTOCOL = 3'd4,
    ERR_CHECKSUM = 3'd5
  } err_e;

  typedef struct packed {
    logic [IdxW-1:0] byte_index;
    logic [15:0]     running_sum;
    logic [7:0]      held_high_byte;
    err_e            first_error;
    logic [15:0]     stored_checksum;
    logic [15:0]     length_seen;
    logic [7:0]      protocol_seen;
  } hv_state_t;

  typedef struct packed {
    logic        header_ok;
    logic [2:0]  error_code;
    logic [15:0] pkt_len;
    logic [7:0]  protocol_number;
    logic [15:0] computed_checksum;
  } hv_result_t;

endpackage

// ----- design/ipv4hv_if.sv -----
// Valid/ready channel interfaces for header bytes in and verdicts out.
// Depends on nothing; field widths follow the block's port definition.
interface ipv4hv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hdr_byte;
  logic       start_of_header;

  modport source (output valid, output hdr_byte, output start_of_header, input ready);
  modport sink   (input valid, input hdr_byte, input start_of_header, output ready);
endinterface

interface ipv4hv_out_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic [2:0]  error_code;
  logic [15:0] pkt_len;
  logic [7:0]  protocol_number;
  logic [15:0] computed_checksum;

  modport source (output valid, output header_ok, output error_code, output pkt_len,
                  output protocol_number, output computed_checksum, input ready);
  modport sink   (input valid, input header_ok, input error_code, input pkt_len,
                  input protocol_number, input computed_checksum, output ready);
endinterface

// ----- design/ipv4_header_verifier_core.sv -----
// IPv4 header verifier: checks a 20-byte header streamed one byte per transaction.
// Path: input register, single step stage, result register. Throughput: one byte
// per cycle, headers back to back, unless a last byte waits for the result slot.
// Reset (rst_ni low, async): byte count, sum and per-header state clear,
// length limits return to 20 and 1500, no transaction pending on either side.
// Depends on ipv4hv_pkg, ipv4hv_if, ipv4hv_step.
module ipv4_header_verifier_core
  import ipv4hv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  ipv4hv_in_if.sink    hdr_i,
  ipv4hv_out_if.source res_o
);

  // input register
  logic       s_valid_q;
  logic [7:0] s_byte_q;
  logic       s_start_q;

  // per-header state and length limits
  hv_state_t   st_q;
  hv_state_t   st_d;
  logic [15:0] min_len_q;
  logic [15:0] max_len_q;

  // result register
  logic       out_valid_q;
  hv_result_t out_q;

  hv_result_t step_res;
  logic       step_last;
  logic       step_go;
  logic       in_take;

  ipv4hv_step u_step (
    .st_i       (st_q),
    .hdr_byte_i (s_byte_q),
    .start_i    (s_start_q),
    .min_len_i  (min_len_q),
    .max_len_i  (max_len_q),
    .st_o       (st_d),
    .last_o     (step_last),
    .res_o      (step_res)
  );

  // A byte that ends a header needs the result slot free (or draining this
  // cycle); every other byte moves through regardless of the output side.
  assign step_go     = s_valid_q && (!step_last || !out_valid_q || res_o.ready);
  assign hdr_i.ready = !s_valid_q || step_go;
  assign in_take     = hdr_i.valid && hdr_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (hdr_i.ready) begin
      s_valid_q <= hdr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s_byte_q  <= hdr_i.hdr_byte;
      s_start_q <= hdr_i.start_of_header;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_go) begin
      st_q <= st_d;
    end
  end

  // limits are to be changed only while idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_LEN: min_len_q <= cfg_data_i;
        CFG_MAX_LEN: max_len_q <= cfg_data_i;
        default:     min_len_q <= min_len_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go && step_last) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && step_last) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.header_ok         = out_q.header_ok;
  assign res_o.error_code        = out_q.error_code;
  assign res_o.pkt_len           = out_q.pkt_len;
  assign res_o.protocol_number   = out_q.protocol_number;
  assign res_o.computed_checksum = out_q.computed_checksum;

`ifndef SYNTHESIS
  // a new verdict only comes from a staged byte in the cycle before
  a_res_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s_valid_q))
    else $error("verdict appeared without a staged byte");

  // a staged byte that cannot move must still be there next cycle
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && !step_go) |=> s_valid_q)
    else $error("stalled byte dropped from input register");

  // byte count never runs past the last header byte
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go |=> (st_q.byte_index <= LastIdx))
    else $error("byte index out of range");
`endif

endmodule

// ----- design/ipv4hv_step.sv -----
// Per-byte update of the header verifier: field capture, checks, checksum add.
// Depends on ipv4hv_pkg.
module ipv4hv_step
  import ipv4hv_pkg::*;
(
  input  hv_state_t   st_i,
  input  logic [7:0]  hdr_byte_i,
  input  logic        start_i,
  input  logic [15:0] min_len_i,
  input  logic [15:0] max_len_i,
  output hv_state_t   st_o,
  output logic        last_o,
  output hv_result_t  res_o
);

  logic [IdxW-1:0] idx;
  hv_state_t       cur;
  hv_state_t       nxt;
  logic [15:0]     word;
  logic [16:0]     sum_wide;
  logic [15:0]     sum_fold;
  logic [15:0]     computed;

  always_comb begin
    idx = start_i ? '0 : st_i.byte_index;
    cur = st_i;
    if (idx == '0) begin
      cur.running_sum     = '0;
      cur.held_high_byte  = '0;
      cur.first_error     = ERR_NONE;
      cur.stored_checksum = '0;
      cur.length_seen     = '0;
      cur.protocol_seen   = '0;
    end
    word = {cur.held_high_byte, hdr_byte_i};
    nxt  = cur;

    unique case (idx)
      IdxVerIhl: begin
        if (hdr_byte_i != VerIhlExpected && nxt.first_error == ERR_NONE)
          nxt.first_error = ERR_VERSION;
      end
      IdxLenLo: begin
        nxt.length_seen = word;
        if ((word < min_len_i || word > max_len_i) && nxt.first_error == ERR_NONE)
          nxt.first_error = ERR_LENGTH;
      end
      IdxFragLo: begin
        if ((word[12:0] & FragOffMask) != '0 && nxt.first_error == ERR_NONE)
          nxt.first_error = ERR_FRAGMENT;
      end
      IdxProto: begin
        nxt.protocol_seen = hdr_byte_i;
        if (hdr_byte_i != ProtoIcmp && hdr_byte_i != ProtoTcp && hdr_byte_i != ProtoUdp
            && nxt.first_error == ERR_NONE)
          nxt.first_error = ERR_PROTOCOL;
      end
      IdxCsumLo: begin
        nxt.stored_checksum = word;
      end
      default: begin
      end
    endcase

    // end-around carry add of the finished big-endian word
    sum_wide = {1'b0, cur.running_sum} + {1'b0, word};
    sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};
    if (!idx[0])
      nxt.held_high_byte = hdr_byte_i;
    else if (idx != IdxCsumLo)
      nxt.running_sum = sum_fold;

    computed = ~nxt.running_sum;
    last_o   = (idx >= LastIdx);
    if (last_o) begin
      nxt.byte_index = '0;
      if (nxt.stored_checksum != computed && nxt.first_error == ERR_NONE)
        nxt.first_error = ERR_CHECKSUM;
    end else begin
      nxt.byte_index = idx + IdxW'(1);
    end

    st_o                    = nxt;
    res_o.header_ok         = (nxt.first_error == ERR_NONE);
    res_o.error_code        = nxt.first_error;
    res_o.pkt_len           = nxt.length_seen;
    res_o.protocol_number   = nxt.protocol_seen;
    res_o.computed_checksum = computed;
  end

endmodule

// ----- tb/ipv4_header_verifier_core_test.sv -----
// Self-checking testbench for ipv4_header_verifier_core: streams 20-byte IPv4 headers
// through the byte channel and checks each verdict against a cycle-free header model.
// Depends on ipv4hv_pkg, ipv4hv_if and the core RTL.
`timescale 1ns / 100ps

module ipv4_header_verifier_core_test;
  import ipv4hv_pkg::*;

  // how the checksum field of a generated header is filled in
  typedef enum logic [1:0] {
    CSUM_GOOD,        // matches the complemented sum
    CSUM_OFF_BY_ONE,  // one above the right value
    CSUM_ZERO,        // stored 0x0000 whatever the sum
    CSUM_ALL_ONES     // address tail tuned so the sum is 0xFFFF, stored 0xFFFF
  } csum_mode_e;

  // one header recipe: the directed table and the random part both use it
  typedef struct {
    logic [7:0]  ver_ihl;
    logic [15:0] tot_len;
    logic [15:0] flags_frag;
    logic [7:0]  proto;
    logic [7:0]  fill;
    logic        rand_fill;   // filler bytes random instead of 'fill'
    csum_mode_e  csum;
    int          lead;        // bytes of an abandoned header sent first
    logic        no_sof;      // byte 0 sent without the start flag
    logic        pinned;      // verdict code typed in below
    err_e        code;
  } hdr_recipe_t;

  typedef logic [7:0] hdr_bytes_t [HdrBytes];

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [15:0] cfg_data_i;

  ipv4hv_in_if  hdr_if ();
  ipv4hv_out_if res_if ();

  ipv4_header_verifier_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .hdr_i      (hdr_if.sink),
    .res_o      (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Header model: its own copy of the length limits and the per-header state.
  // ---------------------------------------------------------------------------
  logic [15:0]     lim_min = MinLenReset;
  logic [15:0]     lim_max = MaxLenReset;
  logic [IdxW-1:0] pos = '0;
  logic [15:0]     ones_sum = '0;
  logic [7:0]      hi_byte = '0;
  err_e            first_fault = ERR_NONE;
  logic [15:0]     csum_field = '0;
  logic [15:0]     len_field = '0;
  logic [7:0]      proto_field = '0;

  hv_result_t pending_verdicts[$];
  int         mismatches = 0;
  int         bytes_sent = 0;
  bit         drive_gaps = 1'b0;
  bit         sink_stalls = 1'b0;

  function automatic void note_fault(err_e code);
    if (first_fault == ERR_NONE) first_fault = code;
  endfunction

  // Advance the model by one accepted byte; queue a verdict on the last byte.
  function automatic void step_header_check(logic [7:0] b, logic sof);
    logic [15:0] word;
    logic [16:0] acc;
    logic [15:0] folded;
    hv_result_t  v;
    if (sof) pos = '0;
    if (pos == IdxVerIhl) begin
      ones_sum    = '0;
      hi_byte     = '0;
      first_fault = ERR_NONE;
      csum_field  = '0;
      len_field   = '0;
      proto_field = '0;
    end
    word = {hi_byte, b};
    case (pos)
      IdxVerIhl: if (b != VerIhlExpected) note_fault(ERR_VERSION);
      IdxLenLo: begin
        len_field = word;
        if (word < lim_min || word > lim_max) note_fault(ERR_LENGTH);
      end
      IdxFragLo: if ((word[12:0] & FragOffMask) != '0) note_fault(ERR_FRAGMENT);
      IdxProto: begin
        proto_field = b;
        if (b != ProtoIcmp && b != ProtoTcp && b != ProtoUdp) note_fault(ERR_PROTOCOL);
      end
      IdxCsumLo: csum_field = word;
      default: ;
    endcase
    // even bytes are held as the high half; odd bytes close a word
    if (!pos[0]) begin
      hi_byte = b;
    end else if (pos != IdxCsumLo) begin
      acc      = {1'b0, ones_sum} + {1'b0, word};
      ones_sum = acc[15:0] + 16'(acc[16]);   // end-around carry
    end
    if (pos >= LastIdx) begin
      pos    = '0;
      folded = ~ones_sum;
      // exact compare: 0x0000 and 0xFFFF are not taken as equal
      if (csum_field != folded) note_fault(ERR_CHECKSUM);
      v.header_ok         = (first_fault == ERR_NONE);
      v.error_code        = first_fault;
      v.pkt_len           = len_field;
      v.protocol_number   = proto_field;
      v.computed_checksum = folded;
      pending_verdicts.push_back(v);
    end else begin
      pos = pos + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Verdict side: random stalls on ready, compare at the falling edge, where
  // valid and ready already hold the values the next rising edge will see.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_if.ready <= !(sink_stalls && $urandom_range(0, 99) < 36);
  end

  task automatic flag_field(string name, logic [15:0] want, logic [15:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    mismatches++;
  endtask

  task automatic check_verdict(hv_result_t got);
    hv_result_t want;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: verdict with none expected, expected nothing, actual %0h",
               $time, got);
      mismatches++;
      return;
    end
    want = pending_verdicts.pop_front();
    if (got.header_ok !== want.header_ok)
      flag_field("header_ok", 16'(want.header_ok), 16'(got.header_ok));
    if (got.error_code !== want.error_code)
      flag_field("error_code", 16'(want.error_code), 16'(got.error_code));
    if (got.pkt_len !== want.pkt_len)
      flag_field("pkt_len", want.pkt_len, got.pkt_len);
    if (got.protocol_number !== want.protocol_number)
      flag_field("protocol_number", 16'(want.protocol_number), 16'(got.protocol_number));
    if (got.computed_checksum !== want.computed_checksum)
      flag_field("computed_checksum", want.computed_checksum, got.computed_checksum);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
      check_verdict({res_if.header_ok, res_if.error_code, res_if.pkt_len,
                     res_if.protocol_number, res_if.computed_checksum});
  end

  // ---------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------

  // One byte transaction: random gaps first, then hold valid until ready.
  // Acceptance is decided at the falling edge before the accepting rising edge.
  task automatic push_byte(logic [7:0] b, logic sof);
    logic took;
    while (drive_gaps && $urandom_range(0, 99) < 36) begin
      hdr_if.valid    <= 1'b0;
      hdr_if.hdr_byte <= 8'($urandom);
      @(posedge clk_i);
    end
    hdr_if.valid           <= 1'b1;
    hdr_if.hdr_byte        <= b;
    hdr_if.start_of_header <= sof;
    do begin
      @(negedge clk_i);
      took = hdr_if.ready;
      if (took) step_header_check(b, sof);
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
  endtask

  // Lay out a header from a recipe and fill in its checksum field.
  task automatic build_header(input hdr_recipe_t r, output hdr_bytes_t h);
    logic [16:0] acc;
    logic [15:0] s;
    logic [15:0] cs;
    foreach (h[i]) h[i] = r.rand_fill ? 8'($urandom) : r.fill;
    h[0]  = r.ver_ihl;
    h[2]  = r.tot_len[15:8];
    h[3]  = r.tot_len[7:0];
    h[6]  = r.flags_frag[15:8];
    h[7]  = r.flags_frag[7:0];
    h[9]  = r.proto;
    h[10] = 8'h00;
    h[11] = 8'h00;
    if (r.csum == CSUM_ALL_ONES) begin
      h[HdrBytes-2] = 8'h00;
      h[HdrBytes-1] = 8'h00;
    end
    s = '0;
    for (int i = 0; i < HdrBytes; i += 2) begin
      acc = {1'b0, s} + {1'b0, h[i], h[i+1]};
      s   = acc[15:0] + 16'(acc[16]);
    end
    case (r.csum)
      CSUM_GOOD:       cs = ~s;
      CSUM_OFF_BY_ONE: cs = ~s + 16'd1;
      CSUM_ZERO:       cs = 16'h0000;
      default: begin
        // the last word brings the sum to 0xFFFF with no carry out
        {h[HdrBytes-2], h[HdrBytes-1]} = 16'hFFFF - s;
        cs = 16'hFFFF;
      end
    endcase
    h[10] = cs[15:8];
    h[11] = cs[7:0];
  endtask

  task automatic stream_header(hdr_recipe_t r);
    hdr_bytes_t h;
    hv_result_t v;
    build_header(r, h);
    for (int i = 0; i < r.lead; i++) push_byte(8'($urandom), i == 0);
    foreach (h[i]) push_byte(h[i], (i == 0) && !r.no_sof);
    // a typed-in verdict code replaces the model's for this header
    if (r.pinned && pending_verdicts.size() != 0) begin
      v = pending_verdicts.pop_back();
      v.header_ok  = (r.code == ERR_NONE);
      v.error_code = r.code;
      pending_verdicts.push_back(v);
    end
  endtask

  // Idle point: byte valid dropped, wait for all verdicts, then a further idle wait.
  task automatic drain_verdicts();
    hdr_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Both limits go in back to back, write enable held across the pair.
  task automatic set_limits(logic [15:0] lo, logic [15:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIN_LEN;
    cfg_data_i <= lo;
    @(posedge clk_i);
    lim_min     = lo;
    cfg_idx_i  <= CFG_MAX_LEN;
    cfg_data_i <= hi;
    @(posedge clk_i);
    lim_max    = hi;
    cfg_we_i  <= 1'b0;
  endtask

  // Length limits per random phase: plain defaults, widest, narrowest at both
  // ends, inverted; the last phase picks its own.
  logic [15:0] phase_min [6] = '{16'd20,   16'd0,     16'd0, 16'hFFFF, 16'd1000, 16'd0};
  logic [15:0] phase_max [6] = '{16'd1500, 16'hFFFF,  16'd0, 16'hFFFF, 16'd100,  16'd0};

  // Directed headers, run with the reset limits of 20 and 1500.
  hdr_recipe_t directed [18];

  initial begin
    hdr_recipe_t r;
    int          pick;
    int          phase_end;

    directed = '{
      // shortest legal header, all-zero filler
      '{8'h45, 16'd20,   16'h0000, ProtoTcp,  8'h00, 1'b0, CSUM_GOOD,       0, 1'b0, 1'b1, ERR_NONE},
      // longest legal length, don't-fragment set, filler all ones
      '{8'h45, 16'd1500, 16'h4000, ProtoUdp,  8'hFF, 1'b0, CSUM_GOOD,       0, 1'b0, 1'b1, ERR_NONE},
      // back to back, no start flag: index wraps on its own
      '{8'h45, 16'd576,  16'hE000, ProtoIcmp, 8'hA5, 1'b0, CSUM_GOOD,       0, 1'b1, 1'b1, ERR_NONE},
      // all zeros: stored 0x0000 against computed 0xFFFF, version reported first
      '{8'h00, 16'h0000, 16'h0000, 8'h00,     8'h00, 1'b0, CSUM_ZERO,       0, 1'b0, 1'b1, ERR_VERSION},
      '{8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF,     8'hFF, 1'b0, CSUM_OFF_BY_ONE, 0, 1'b0, 1'b1, ERR_VERSION},
      '{8'h45, 16'd19,   16'h0000, ProtoTcp,  8'h5A, 1'b0, CSUM_GOOD,       0, 1'b0, 1'b1, ERR_LENGTH},
      '{8'h45, 16'd1501, 16'h0000, ProtoTcp,  8'h5A, 1'b0, CSUM_GOOD,       0, 1'b0, 1'b1, ERR_LENGTH},
      '{8'h45, 16'hFFFF, 16'h1FFF, 8'h00,     8'h33, 1'b0, CSUM_OFF_BY_ONE, 0, 1'b0, 1'b1, ERR_LENGTH},
      '{8'h45, 16'd40,   16'h0001, ProtoUdp,  8'h81, 1'b0, CSUM_GOOD,       0, 1'b0, 1'b1, ERR_FRAGMENT},
      '{8'h45, 16'd40,   16'hFFFF, ProtoUdp,  8'h18, 1'b0, CSUM_GOOD,       0, 1'b0, 1'b1, ERR_FRAGMENT},
      '{8'h45, 16'd60,   16'h0000, 8'h00,     8'h7E, 1'b0, CSUM_GOOD,       0, 1'b0, 1'b1, ERR_PROTOCOL},
      '{8'h45, 16'd60,   16'h4000, 8'hFF,     8'hE7, 1'b0, CSUM_GOOD,       0, 1'b0, 1'b1, ERR_PROTOCOL},
      '{8'h45, 16'd100,  16'h0000, ProtoUdp,  8'h42, 1'b0, CSUM_OFF_BY_ONE, 0, 1'b0, 1'b1, ERR_CHECKSUM},
      // stored 0xFFFF against computed 0x0000
      '{8'h45, 16'd100,  16'h0000, ProtoTcp,  8'h24, 1'b0, CSUM_ALL_ONES,   0, 1'b0, 1'b1, ERR_CHECKSUM},
      // restart in mid-header after 7 bytes
      '{8'h45, 16'd20,   16'h0000, ProtoIcmp, 8'h3C, 1'b0, CSUM_GOOD,       7, 1'b0, 1'b1, ERR_NONE},
      '{8'h46, 16'd0,    16'h0001, 8'h00,     8'h99, 1'b0, CSUM_OFF_BY_ONE, 0, 1'b0, 1'b1, ERR_VERSION},
      // random filler, model only
      '{8'h45, 16'd1000, 16'h2000, ProtoTcp,  8'h00, 1'b1, CSUM_GOOD,       0, 1'b0, 1'b0, ERR_NONE},
      // restart one byte short of a full header
      '{8'h45, 16'd20,   16'h0000, ProtoUdp,  8'hC3, 1'b0, CSUM_GOOD,      19, 1'b0, 1'b1, ERR_NONE}
    };

    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= CFG_MIN_LEN;
    cfg_data_i             <= '0;
    hdr_if.valid           <= 1'b0;
    hdr_if.hdr_byte        <= '0;
    hdr_if.start_of_header <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, with gaps and stalls on
    drive_gaps  = 1'b1;
    sink_stalls = 1'b1;
    foreach (directed[i]) stream_header(directed[i]);
    drain_verdicts();

    // random headers, one phase per limit setting; phase 0 runs without
    // any gaps or stalls so headers go through at full rate
    bytes_sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      drive_gaps  = (ph != 0);
      sink_stalls = (ph != 0);
      if (ph == 5) begin
        phase_min[ph] = 16'($urandom_range(0, 2000));
        phase_max[ph] = 16'($urandom_range(phase_min[ph], 65535));
      end
      set_limits(phase_min[ph], phase_max[ph]);
      phase_end = (ph + 1) * 270;
      while (bytes_sent < phase_end) begin
        // about one time in ten a burst of loose bytes with stray start flags
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 30)) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
        r.ver_ihl = ($urandom_range(0, 9) == 0) ? 8'($urandom) : VerIhlExpected;
        pick = $urandom_range(0, 9);
        case (pick)
          0: r.tot_len = 16'($urandom);
          1: r.tot_len = lim_min;
          2: r.tot_len = lim_max;
          3: r.tot_len = lim_min - 16'd1;
          4: r.tot_len = lim_max + 16'd1;
          default: r.tot_len = (lim_min <= lim_max) ?
                                 16'($urandom_range(lim_min, lim_max)) : 16'($urandom);
        endcase
        // flag bits random, offset mostly zero
        r.flags_frag = {3'($urandom), 13'h0};
        if ($urandom_range(0, 9) == 0) r.flags_frag[12:0] = 13'($urandom);
        pick = $urandom_range(0, 9);
        r.proto = (pick < 3) ? ProtoIcmp : (pick < 6) ? ProtoTcp :
                  (pick < 9) ? ProtoUdp : 8'($urandom);
        r.fill      = '0;
        r.rand_fill = 1'b1;
        pick = $urandom_range(0, 99);
        r.csum = (pick < 85) ? CSUM_GOOD : (pick < 95) ? CSUM_OFF_BY_ONE :
                 (pick < 98) ? CSUM_ZERO : CSUM_ALL_ONES;
        r.lead   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
        r.no_sof = (r.lead == 0) && ($urandom_range(0, 6) == 0);
        r.pinned = 1'b0;
        r.code   = ERR_NONE;
        stream_header(r);
      end
      drain_verdicts();
    end

    // last waits: bounded wait for stragglers, then a quiet window in which
    // any extra verdict shows up as unexpected
    for (int w = 0; w < 1000 && pending_verdicts.size() != 0; w++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: verdicts missing, expected %0d more, actual 0", $time,
               pending_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("PASS ipv4_header_verifier_core");
    else
      $display("FAIL ipv4_header_verifier_core");
    $finish;
  end

  // watchdog, far above the slowest expected run
  initial begin
    #2_000_000;
    $display("FAIL ipv4_header_verifier_core");
    $finish;
  end

endmodule

// ----- ipv4_header_verifier_core.f -----
design/ipv4hv_pkg.sv
design/ipv4hv_if.sv
design/ipv4hv_step.sv
design/ipv4_header_verifier_core.sv
tb/ipv4_header_verifier_core_test.sv
